@@ sv/tcpoor_pkg.sv @@
// ============================================================================
// tcpoor_pkg - shared types for the TCP out-of-order reassembly table
// Request and result formats, result kinds, operation codes, command and
// status bundles between controller and datapath, sequence compare.
// ============================================================================
package tcpoor_pkg;

    localparam int SEQ_W       = 32;
    localparam int LEN_W       = 16;
    localparam int SLOT_W      = 4;
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef enum logic [1:0] {
        KIND_INS_OK   = 2'd0,
        KIND_INS_FULL = 2'd1,
        KIND_DRAINED  = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef struct packed {
        logic              operation;
        logic [SEQ_W-1:0]  segment_seq;
        logic [LEN_W-1:0]  segment_len;
        logic [SLOT_W-1:0] buffer_slot;
        logic [SEQ_W-1:0]  expected_seq;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [LEN_W-1:0]  out_len;
        logic [SLOT_W-1:0] out_slot;
        logic [SEQ_W-1:0]  next_expected;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS_SCAN,
        S_DR_SCAN,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic reject;
        logic insert;
        logic step;
        logic take;
        logic finish;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic in_op;
        logic full;
        logic at_end;
        logic ins_here;
        logic hit;
        logic later;
        logic limit;
        logic pend_valid;
        logic out_free;
    } sts_t;

    function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] diff;
        diff = a - b;
        return diff[SEQ_W-1];
    endfunction

endpackage

@@ sv/tcpoor_ctrl.sv @@
// ============================================================================
// tcpoor_ctrl - sequencing state machine
// Steps an insert scan or a drain walk one entry per cycle (a drain stalls on
// a blocked result) and hands the closing result to the output register.
// ============================================================================
module tcpoor_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcpoor_pkg::sts_t   sts,
    output tcpoor_pkg::cmd_t   cmd
);

    tcpoor_pkg::state_t state_reg;
    tcpoor_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcpoor_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tcpoor_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_op == tcpoor_pkg::OP_INSERT)
                    begin
                        state_next = tcpoor_pkg::S_INS_SCAN;
                    end
                    else
                    begin
                        state_next = tcpoor_pkg::S_DR_SCAN;
                    end
                end
            end
            tcpoor_pkg::S_INS_SCAN:
            begin
                if (sts.full)
                begin
                    cmd.reject = 1'b1;
                    state_next = tcpoor_pkg::S_FLUSH;
                end
                else if (sts.at_end || sts.ins_here)
                begin
                    cmd.insert = 1'b1;
                    state_next = tcpoor_pkg::S_FLUSH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            tcpoor_pkg::S_DR_SCAN:
            begin
                if (sts.at_end || sts.limit || (!sts.hit && sts.later))
                begin
                    cmd.finish = 1'b1;
                    state_next = tcpoor_pkg::S_FLUSH;
                end
                else if (sts.hit)
                begin
                    // hold while the previous drained request cannot leave
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.take = 1'b1;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            tcpoor_pkg::S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = tcpoor_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tcpoor_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/tcpoor_dpath.sv @@
// ============================================================================
// tcpoor_dpath - sorted descriptor table and result registers
// Holds the sorted entries, the walk pointer, the expected sequence, one
// pending result and the output register.
// ============================================================================
module tcpoor_dpath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcpoor_pkg::in_item_t  in_data,
    output tcpoor_pkg::out_item_t out_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tcpoor_pkg::cmd_t      cmd,
    output tcpoor_pkg::sts_t      sts
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [tcpoor_pkg::SEQ_W-1:0]  seq_tab_reg  [TABLE_DEPTH];
    logic [tcpoor_pkg::LEN_W-1:0]  len_tab_reg  [TABLE_DEPTH];
    logic [tcpoor_pkg::SLOT_W-1:0] slot_tab_reg [TABLE_DEPTH];

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      idx_reg;
    logic [tcpoor_pkg::NRES_W-1:0]      nres_reg;
    logic                               pend_valid_reg;
    logic                               out_valid_reg;
    tcpoor_pkg::out_item_t              pend_reg;
    tcpoor_pkg::out_item_t              out_reg;
    logic [tcpoor_pkg::SEQ_W-1:0]       exp_reg;
    logic [tcpoor_pkg::SEQ_W-1:0]       seg_seq_reg;
    logic [tcpoor_pkg::LEN_W-1:0]       seg_len_reg;
    logic [tcpoor_pkg::SLOT_W-1:0]      seg_slot_reg;

    logic [tcpoor_pkg::SEQ_W-1:0]  rd_seq;
    logic [tcpoor_pkg::LEN_W-1:0]  rd_len;
    logic [tcpoor_pkg::SLOT_W-1:0] rd_slot;
    logic [tcpoor_pkg::SEQ_W-1:0]  exp_next;
    logic                          out_free;
    tcpoor_pkg::out_item_t         pend_next;
    tcpoor_pkg::out_item_t         out_next;

    assign rd_seq   = seq_tab_reg[idx_reg[AW-1:0]];
    assign rd_len   = len_tab_reg[idx_reg[AW-1:0]];
    assign rd_slot  = slot_tab_reg[idx_reg[AW-1:0]];
    assign exp_next = exp_reg + {{(tcpoor_pkg::SEQ_W - tcpoor_pkg::LEN_W){1'b0}}, rd_len};
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts            = '0;
        sts.in_op      = in_data.operation;
        sts.full       = (count_reg == CW'(TABLE_DEPTH));
        sts.at_end     = (idx_reg == count_reg);
        sts.ins_here   = tcpoor_pkg::seq_before(seg_seq_reg, rd_seq);
        sts.hit        = (rd_seq == exp_reg);
        sts.later      = tcpoor_pkg::seq_before(exp_reg, rd_seq);
        sts.limit      = (nres_reg == tcpoor_pkg::NRES_W'(tcpoor_pkg::MAX_RESULTS));
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
    end

    // table: shift up on insert, shift down on removal
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (cmd.insert)
            begin
                if (CW'(j) == idx_reg)
                begin
                    seq_tab_reg[j]  <= seg_seq_reg;
                    len_tab_reg[j]  <= seg_len_reg;
                    slot_tab_reg[j] <= seg_slot_reg;
                end
                else if ((j > 0) && (CW'(j) > idx_reg))
                begin
                    seq_tab_reg[j]  <= seq_tab_reg[(j > 0) ? j - 1 : 0];
                    len_tab_reg[j]  <= len_tab_reg[(j > 0) ? j - 1 : 0];
                    slot_tab_reg[j] <= slot_tab_reg[(j > 0) ? j - 1 : 0];
                end
            end
            else if (cmd.take)
            begin
                if ((j < TABLE_DEPTH - 1) && (CW'(j) >= idx_reg))
                begin
                    seq_tab_reg[j]  <= seq_tab_reg[(j < TABLE_DEPTH - 1) ? j + 1 : j];
                    len_tab_reg[j]  <= len_tab_reg[(j < TABLE_DEPTH - 1) ? j + 1 : j];
                    slot_tab_reg[j] <= slot_tab_reg[(j < TABLE_DEPTH - 1) ? j + 1 : j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            nres_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= '0;
                nres_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.take)
            begin
                count_reg <= count_reg - 1'b1;
                nres_reg  <= nres_reg + 1'b1;
            end
            if (cmd.reject || cmd.insert || cmd.take || cmd.finish)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.flush || (cmd.take && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd.reject || cmd.insert)
        begin
            pend_next      = '0;
            pend_next.kind = cmd.reject ? tcpoor_pkg::KIND_INS_FULL
                                        : tcpoor_pkg::KIND_INS_OK;
        end
        if (cmd.take)
        begin
            pend_next.kind          = tcpoor_pkg::KIND_DRAINED;
            pend_next.out_seq       = rd_seq;
            pend_next.out_len       = rd_len;
            pend_next.out_slot      = rd_slot;
            pend_next.next_expected = exp_next;
            pend_next.last          = 1'b0;
        end
        if (cmd.finish && !pend_valid_reg)
        begin
            pend_next               = '0;
            pend_next.kind          = tcpoor_pkg::KIND_NONE;
            pend_next.next_expected = exp_reg;
        end
        out_next      = pend_reg;
        out_next.last = cmd.flush;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seg_seq_reg  <= in_data.segment_seq;
            seg_len_reg  <= in_data.segment_len;
            seg_slot_reg <= in_data.buffer_slot;
            exp_reg      <= in_data.expected_seq;
        end
        if (cmd.take)
        begin
            exp_reg <= exp_next;
        end
        pend_reg <= pend_next;
        if (cmd.flush || (cmd.take && pend_valid_reg))
        begin
            out_reg <= out_next;
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ sv/tcp_out_of_order_reassembly_table.sv @@
// ============================================================================
// tcp_out_of_order_reassembly_table - out-of-order segment descriptor table
// Sorted table of TCP segment descriptors with insert and in-order drain.
// ============================================================================
// Requests are taken one at a time. An insert scans the sorted table one
// entry per cycle for its place before its single result is offered. A drain
// walks the table from the head one entry per cycle, pausing on a match
// while the previous drained segment cannot leave; a matching entry is
// removed in the same cycle as it is read, and each drained segment is held
// back in the pending register so that the final one can carry last. The
// walk through the table is the limit on rate: the next request is accepted
// only once the final result has moved to the output register, later if
// results are not taken.
module tcp_out_of_order_reassembly_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tcpoor_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tcpoor_pkg::out_item_t out_data
);

    tcpoor_pkg::cmd_t cmd;
    tcpoor_pkg::sts_t sts;

    tcpoor_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcpoor_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
